// ===== src/anxb_pkg.sv =====
// Shared types, codes and header decode for the Annex B NAL unit extractor.
// No dependencies; used by anxb_result_queue and annex_b_nal_unit_extractor.
package anxb_pkg;

    typedef enum logic [1:0] {
        SYN_AUTO = 2'd0,
        SYN_H264 = 2'd1,
        SYN_HEVC = 2'd2,
        SYN_VVC  = 2'd3
    } t_nal_syntax;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_DESC    = 1'b1;

    localparam int MAX_RESULTS  = 6;
    localparam int RES_IDX_BITS = $clog2(MAX_RESULTS);
    localparam int RES_CNT_BITS = $clog2(MAX_RESULTS + 1);

    localparam logic [5:0] H264_IDR_TYPE = 6'd5;
    localparam logic [5:0] HEVC_KEY_LO   = 6'd32;
    localparam logic [5:0] HEVC_KEY_HI   = 6'd35;
    localparam logic [5:0] VVC_KEY_LO    = 6'd7;
    localparam logic [5:0] VVC_KEY_HI    = 6'd10;
    localparam logic [5:0] VVC_IDR_LO    = 6'd7;
    localparam logic [5:0] VVC_IDR_HI    = 6'd8;

    typedef struct packed {
        logic [5:0] unit_type;
        logic       is_key;
        logic       is_idr;
    } t_hdr_info;

    function automatic t_hdr_info f_hdr_info(t_nal_syntax syn, logic [7:0] h0, logic [7:0] h1);
        t_hdr_info v;
        v = '0;
        unique case (syn)
            SYN_HEVC: begin
                v.unit_type = h0[6:1];
                v.is_key    = (v.unit_type >= HEVC_KEY_LO) && (v.unit_type <= HEVC_KEY_HI);
            end
            SYN_VVC: begin
                v.unit_type = {1'b0, h1[7:3]};
                v.is_key    = (v.unit_type >= VVC_KEY_LO) && (v.unit_type <= VVC_KEY_HI);
                v.is_idr    = (v.unit_type >= VVC_IDR_LO) && (v.unit_type <= VVC_IDR_HI);
            end
            SYN_AUTO, SYN_H264: begin
                v.unit_type = {1'b0, h0[4:0]};
                v.is_key    = (v.unit_type == H264_IDR_TYPE);
                v.is_idr    = v.is_key;
            end
        endcase
        return v;
    endfunction

endpackage

// ===== src/anxb_result_queue.sv =====
// Result batch buffer and output register for the NAL unit extractor. Uses anxb_pkg.
// Holds all results of one input transfer and drains them one per cycle unless stalled.
module anxb_result_queue
    import anxb_pkg::*;
#(
    parameter int DATA_BITS = 42
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  logic [RES_CNT_BITS-1:0]                i_count,
    input  logic [MAX_RESULTS-1:0][DATA_BITS-1:0]  i_data,
    output logic                                   o_can_load,
    output logic                                   o_valid,
    output logic [DATA_BITS-1:0]                   o_data,
    input  logic                                   i_ready
);

    logic [DATA_BITS-1:0]    r_buf [MAX_RESULTS];
    logic [RES_CNT_BITS-1:0] r_cnt;
    logic [RES_IDX_BITS-1:0] r_rd;
    logic [DATA_BITS-1:0]    r_out;
    logic                    r_out_vld;
    logic                    w_move;

    assign w_move     = (r_cnt != '0) && (!r_out_vld || i_ready);
    assign o_can_load = (r_cnt == '0) || ((r_cnt == RES_CNT_BITS'(1)) && w_move);
    assign o_valid    = r_out_vld;
    assign o_data     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_rd      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_load) begin
                r_cnt <= i_count;
                r_rd  <= '0;
            end else if (w_move) begin
                r_cnt <= r_cnt - RES_CNT_BITS'(1);
                r_rd  <= r_rd + RES_IDX_BITS'(1);
            end
            if (w_move) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                r_buf[i] <= i_data[i];
            end
        end
        if (w_move) begin
            r_out <= r_buf[r_rd];
        end
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RES_CNT_BITS'(MAX_RESULTS))
        else $error("result count out of range");
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (({1'b0, r_rd} + {1'b0, r_cnt}) <= (RES_CNT_BITS + 1)'(MAX_RESULTS)))
        else $error("read index past batch end");
    a_move_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_vld)
        else $error("moved result not presented");
    a_empty_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) && !i_load |=> (r_cnt == '0))
        else $error("results appeared without a load");
`endif

endmodule

// ===== src/annex_b_nal_unit_extractor.sv =====
// Top level of the Annex B NAL unit extractor: start code search, header strip, descriptors.
// Depends on anxb_pkg and anxb_result_queue.
//
// channel   dir  signals                           contents
// s_axis    in   tdata[7:0], tlast                 stream byte; tlast = end of buffer
// m_axis    out  tdata, tuser, tlast               payload byte or descriptor; tlast = last of run
// cfg       in   i_cfg_we, i_cfg_wdata[1:0]         header syntax register
//
// One stream byte is processed per cycle unless output stalls; each transfer yields 0 to 5
// results. Results leave one per cycle while m_axis_tready is high, so the rate is one byte
// per cycle while each byte gives at most one result; a byte with more results holds the input
// until its last result moves out. Each result passes the batch buffer and the output register.
// Reset is synchronous; no clearing pass. Output stalls back up through the batch buffer.
module annex_b_nal_unit_extractor
    import anxb_pkg::*;
#(
    parameter int SIZE_COUNT_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // in_byte
    input  logic                   s_axis_tlast,   // end_of_buffer
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [((SIZE_COUNT_BITS + 23) / 8) * 8 - 1:0] m_axis_tdata,
                                                   // payload_byte, unit_type, is_key,
                                                   // is_idr, payload_size, zero pad
    output logic                   m_axis_tuser,   // result_kind
    output logic                   m_axis_tlast,   // last_of_run
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_wdata
);

    localparam int SB         = SIZE_COUNT_BITS;
    localparam int FIELD_BITS = 16 + SB;
    localparam int TDATA_BITS = ((FIELD_BITS + 7) / 8) * 8;
    localparam logic [SB-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic          result_kind;
        logic [7:0]    payload_byte;
        logic [5:0]    unit_type;
        logic          is_key;
        logic          is_idr;
        logic [SB-1:0] payload_size;
        logic          last_of_run;
    } t_res;

    localparam int RES_BITS = $bits(t_res);

    function automatic t_res f_desc(t_nal_syntax syn, logic [7:0] h0, logic [7:0] h1,
                                    logic [SB-1:0] cnt);
        t_res      r;
        t_hdr_info h;
        logic [SB-1:0] hl;
        r  = '0;
        hl = ((syn == SYN_HEVC) || (syn == SYN_VVC)) ? SB'(2) : SB'(1);
        h  = f_hdr_info(syn, h0, h1);
        r.result_kind = KIND_DESC;
        if (cnt >= hl) begin
            r.unit_type    = h.unit_type;
            r.is_key       = h.is_key;
            r.is_idr       = h.is_idr;
            r.payload_size = (cnt == CNT_MAX) ? CNT_MAX : cnt - hl;
        end
        return r;
    endfunction

    t_nal_syntax   r_nal_syntax;
    logic [7:0]    r_win [4];
    logic [2:0]    r_win_fill;
    logic          r_inside;
    logic [7:0]    r_hdr0;
    logic [7:0]    r_hdr1;
    logic [SB-1:0] r_cnt;

    logic [7:0]    n_win [4];
    logic [2:0]    n_win_fill;
    logic          n_inside;
    logic [7:0]    n_hdr0;
    logic [7:0]    n_hdr1;
    logic [SB-1:0] n_cnt;

    logic [MAX_RESULTS-1:0][RES_BITS-1:0] w_batch;
    logic [RES_CNT_BITS-1:0]              w_count;
    logic                                 w_accept;
    logic [RES_BITS-1:0]                  w_out_bits;
    t_res                                 w_out;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        logic [7:0]    v_win [4];
        logic [7:0]    v_old [4];
        logic [7:0]    v_tk [4];
        logic [2:0]    v_fill;
        logic [2:0]    v_tk_n;
        logic [2:0]    v_drop;
        logic          v_inside;
        logic [7:0]    v_hdr0;
        logic [7:0]    v_hdr1;
        logic [SB-1:0] v_cnt;
        logic [SB-1:0] v_hl;
        logic          v_code4;
        logic          v_code3;
        t_res          v_res [MAX_RESULTS];
        t_res          v_pay;
        logic [RES_CNT_BITS-1:0] v_k;

        v_win    = r_win;
        v_fill   = r_win_fill;
        v_inside = r_inside;
        v_hdr0   = r_hdr0;
        v_hdr1   = r_hdr1;
        v_cnt    = r_cnt;
        v_k      = '0;
        v_tk_n   = '0;
        v_drop   = '0;
        v_code4  = 1'b0;
        v_code3  = 1'b0;
        v_pay    = '0;
        v_hl     = ((r_nal_syntax == SYN_HEVC) || (r_nal_syntax == SYN_VVC)) ? SB'(2) : SB'(1);
        for (int i = 0; i < 4; i++) begin
            v_tk[i]  = '0;
            v_old[i] = '0;
        end
        for (int i = 0; i < MAX_RESULTS; i++) begin
            v_res[i] = '0;
        end

        v_win[v_fill[1:0]] = s_axis_tdata;
        v_fill = v_fill + 3'd1;

        if (v_fill == 3'd4) begin
            v_code4 = (v_win[0] == 8'h00) && (v_win[1] == 8'h00) && (v_win[2] == 8'h00)
                      && (v_win[3] == 8'h01);
            v_code3 = !v_code4 && (v_win[0] == 8'h00) && (v_win[1] == 8'h00)
                      && (v_win[2] == 8'h01);
            if (v_code4 || v_code3) begin
                if (v_inside && (v_cnt != '0)) begin
                    v_res[v_k[RES_IDX_BITS-1:0]] = f_desc(r_nal_syntax, v_hdr0, v_hdr1, v_cnt);
                    v_k = v_k + RES_CNT_BITS'(1);
                end
                v_cnt    = '0;
                v_hdr0   = '0;
                v_hdr1   = '0;
                v_inside = 1'b1;
                v_drop   = v_code4 ? 3'd4 : 3'd3;
            end else begin
                v_tk[0] = v_win[0];
                v_tk_n  = 3'd1;
                v_drop  = 3'd1;
            end
            v_old = v_win;
            for (int i = 0; i < 4; i++) begin
                if (i + int'(v_drop) < 4) begin
                    v_win[i] = v_old[2'(i + int'(v_drop))];
                end else begin
                    v_win[i] = '0;
                end
            end
            v_fill = v_fill - v_drop;
        end

        if (s_axis_tlast) begin
            for (int i = 0; i < 3; i++) begin
                if (3'(i) < v_fill) begin
                    v_tk[2'(v_tk_n) + 2'(i)] = v_win[i];
                end
            end
            v_tk_n = v_tk_n + v_fill;
        end

        for (int i = 0; i < 4; i++) begin
            if ((3'(i) < v_tk_n) && v_inside) begin
                if (v_cnt == '0) begin
                    v_hdr0 = v_tk[i];
                end else if (v_cnt == SB'(1)) begin
                    v_hdr1 = v_tk[i];
                end
                if (v_cnt >= v_hl) begin
                    v_pay              = '0;
                    v_pay.result_kind  = KIND_PAYLOAD;
                    v_pay.payload_byte = v_tk[i];
                    v_res[v_k[RES_IDX_BITS-1:0]] = v_pay;
                    v_k = v_k + RES_CNT_BITS'(1);
                end
                if (v_cnt != CNT_MAX) begin
                    v_cnt = v_cnt + SB'(1);
                end
            end
        end

        if (s_axis_tlast) begin
            if (v_inside && (v_cnt != '0)) begin
                v_res[v_k[RES_IDX_BITS-1:0]] = f_desc(r_nal_syntax, v_hdr0, v_hdr1, v_cnt);
                v_k = v_k + RES_CNT_BITS'(1);
            end
            v_cnt    = '0;
            v_hdr0   = '0;
            v_hdr1   = '0;
            v_inside = 1'b0;
            v_fill   = '0;
        end

        if (v_k != '0) begin
            v_res[RES_IDX_BITS'(v_k - RES_CNT_BITS'(1))].last_of_run = 1'b1;
        end

        for (int i = 0; i < MAX_RESULTS; i++) begin
            w_batch[i] = v_res[i];
        end
        w_count    = v_k;
        n_win      = v_win;
        n_win_fill = v_fill;
        n_inside   = v_inside;
        n_hdr0     = v_hdr0;
        n_hdr1     = v_hdr1;
        n_cnt      = v_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nal_syntax <= SYN_AUTO;
            r_win_fill   <= '0;
            r_inside     <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_nal_syntax <= t_nal_syntax'(i_cfg_wdata);
            end
            if (w_accept) begin
                r_win_fill <= n_win_fill;
                r_inside   <= n_inside;
                r_cnt      <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_win  <= n_win;
            r_hdr0 <= n_hdr0;
            r_hdr1 <= n_hdr1;
        end
    end

    anxb_result_queue #(
        .DATA_BITS (RES_BITS)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_count    (w_count),
        .i_data     (w_batch),
        .o_can_load (s_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_data     (w_out_bits),
        .i_ready    (m_axis_tready)
    );

    assign w_out        = t_res'(w_out_bits);
    assign m_axis_tuser = w_out.result_kind;
    assign m_axis_tlast = w_out.last_of_run;
    assign m_axis_tdata = TDATA_BITS'({w_out.payload_size, w_out.is_idr, w_out.is_key,
                                       w_out.unit_type, w_out.payload_byte});

`ifndef SYNTH
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_win_fill <= 3'd3)
        else $error("window fill out of range");
    a_outside_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_inside |-> (r_cnt == '0))
        else $error("byte count outside a unit");
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && s_axis_tlast |=> (r_win_fill == '0) && !r_inside)
        else $error("end of buffer did not flush");
`endif

endmodule
